/* design/nqfs_pkg.sv */
// ----------------------------------------------------------------------------
// nqfs_pkg
// Shared types and the control store of the N-queens search sequencer.
// ----------------------------------------------------------------------------
package nqfs_pkg;

	localparam int StepW = 4;
	typedef logic [StepW-1:0] step_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_INC_COL,
		ACT_PLACE,
		ACT_POP,
		ACT_UNPLACE,
		ACT_CLR_ROW,
		ACT_EMIT,
		ACT_EMIT_IMP
	} act_t;

	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NOSTART,
		CND_BAD,
		CND_ROW_EQ_N,
		CND_COL_EQ_N,
		CND_FREE,
		CND_ROW_ZERO,
		CND_NOT_LAST
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic start;
		logic bad;
		logic row_eq_n;
		logic col_eq_n;
		logic free;
		logic row_zero;
		logic not_last;
	} flags_t;

	localparam step_t ST_WAIT     = 4'd0;
	localparam step_t ST_CHECK    = 4'd1;
	localparam step_t ST_ROW_TEST = 4'd2;
	localparam step_t ST_COL_TEST = 4'd3;
	localparam step_t ST_FREE     = 4'd4;
	localparam step_t ST_NEXT_COL = 4'd5;
	localparam step_t ST_PLACE    = 4'd6;
	localparam step_t ST_BACK     = 4'd7;
	localparam step_t ST_POP      = 4'd8;
	localparam step_t ST_UNPLACE  = 4'd9;
	localparam step_t ST_OUT_INIT = 4'd10;
	localparam step_t ST_OUT      = 4'd11;
	localparam step_t ST_OUT_DONE = 4'd12;
	localparam step_t ST_IMP      = 4'd13;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{act: ACT_NONE, cond: CND_ALWAYS, target: ST_WAIT};
		case (step)
			ST_WAIT:     w = '{act: ACT_LOAD,     cond: CND_NOSTART,  target: ST_WAIT};
			ST_CHECK:    w = '{act: ACT_NONE,     cond: CND_BAD,      target: ST_IMP};
			ST_ROW_TEST: w = '{act: ACT_NONE,     cond: CND_ROW_EQ_N, target: ST_OUT_INIT};
			ST_COL_TEST: w = '{act: ACT_NONE,     cond: CND_COL_EQ_N, target: ST_BACK};
			ST_FREE:     w = '{act: ACT_NONE,     cond: CND_FREE,     target: ST_PLACE};
			ST_NEXT_COL: w = '{act: ACT_INC_COL,  cond: CND_ALWAYS,   target: ST_COL_TEST};
			ST_PLACE:    w = '{act: ACT_PLACE,    cond: CND_ALWAYS,   target: ST_ROW_TEST};
			ST_BACK:     w = '{act: ACT_NONE,     cond: CND_ROW_ZERO, target: ST_IMP};
			ST_POP:      w = '{act: ACT_POP,      cond: CND_NEVER,    target: ST_WAIT};
			ST_UNPLACE:  w = '{act: ACT_UNPLACE,  cond: CND_ALWAYS,   target: ST_COL_TEST};
			ST_OUT_INIT: w = '{act: ACT_CLR_ROW,  cond: CND_NEVER,    target: ST_WAIT};
			ST_OUT:      w = '{act: ACT_EMIT,     cond: CND_NOT_LAST, target: ST_OUT};
			ST_OUT_DONE: w = '{act: ACT_NONE,     cond: CND_ALWAYS,   target: ST_WAIT};
			ST_IMP:      w = '{act: ACT_EMIT_IMP, cond: CND_ALWAYS,   target: ST_WAIT};
			default:     w = '{act: ACT_NONE,     cond: CND_ALWAYS,   target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

/* design/nqfs_useq.sv */
// ----------------------------------------------------------------------------
// nqfs_useq
// Step counter and control store; selects the next step from the jump condition.
// ----------------------------------------------------------------------------
module nqfs_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  nqfs_pkg::flags_t flags,
	output nqfs_pkg::uword_t uword,
	output logic            busy
);
	import nqfs_pkg::*;

	step_t step_q;
	logic  take;

	assign uword = ucode(step_q);
	assign busy  = (step_q != ST_WAIT);

	always_comb begin
		case (uword.cond)
			CND_NEVER:    take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_NOSTART:  take = !flags.start;
			CND_BAD:      take = flags.bad;
			CND_ROW_EQ_N: take = flags.row_eq_n;
			CND_COL_EQ_N: take = flags.col_eq_n;
			CND_FREE:     take = flags.free;
			CND_ROW_ZERO: take = flags.row_zero;
			CND_NOT_LAST: take = flags.not_last;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else if (take) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

/* design/nqfs_dpath.sv */
// ----------------------------------------------------------------------------
// nqfs_dpath
// Search datapath: row and column counters, attack masks, column stack and
// registered result beat.
// ----------------------------------------------------------------------------
module nqfs_dpath #(
	parameter int MAX_BOARD = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [4:0]       board_size,
	input  nqfs_pkg::uword_t uword,
	output nqfs_pkg::flags_t flags,
	output logic             valid,
	output logic [3:0]       queen_column,
	output logic             is_last,
	output logic             impossible
);
	import nqfs_pkg::*;

	localparam int Limit = (MAX_BOARD < 16) ? MAX_BOARD : 16;
	localparam int RW    = $clog2(MAX_BOARD + 1);
	localparam int CW    = $clog2(MAX_BOARD);
	localparam int DN    = 2 * MAX_BOARD - 1;
	localparam int DW    = $clog2(DN);

	logic [RW-1:0]        n_q;
	logic                 bad_q;
	logic [RW-1:0]        row_q;
	logic [RW-1:0]        col_q;
	logic [MAX_BOARD-1:0] col_used_q;
	logic [DN-1:0]        dn_used_q;
	logic [DN-1:0]        up_used_q;
	logic [3:0]           stack_q [MAX_BOARD];
	logic                 valid_q;
	logic [3:0]           queen_column_q;
	logic                 is_last_q;
	logic                 impossible_q;

	logic [CW-1:0]        col_idx;
	logic [CW-1:0]        row_idx;
	logic [CW-1:0]        prev_idx;
	logic [DW-1:0]        dn_idx;
	logic [DW-1:0]        up_idx;
	logic [RW-1:0]        row_dec;

	assign col_idx  = col_q[CW-1:0];
	assign row_idx  = row_q[CW-1:0];
	assign row_dec  = row_q - RW'(1);
	assign prev_idx = row_dec[CW-1:0];
	assign dn_idx   = DW'(row_q) + DW'(n_q) - DW'(1) - DW'(col_q);
	assign up_idx   = DW'(row_q) + DW'(col_q);

	always_comb begin
		flags.start    = start;
		flags.bad      = bad_q;
		flags.row_eq_n = (row_q == n_q);
		flags.col_eq_n = (col_q == n_q);
		flags.free     = !col_used_q[col_idx] && !dn_used_q[dn_idx] && !up_used_q[up_idx];
		flags.row_zero = (row_q == '0);
		flags.not_last = (row_q != n_q - RW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else begin
			valid_q <= 1'b0;
			case (uword.act)
				ACT_LOAD: begin
					if (start) begin
						row_q <= '0;
					end
				end
				ACT_PLACE: row_q <= row_q + RW'(1);
				ACT_POP:   row_q <= row_dec;
				ACT_CLR_ROW: row_q <= '0;
				ACT_EMIT: begin
					valid_q <= 1'b1;
					row_q   <= row_q + RW'(1);
				end
				ACT_EMIT_IMP: valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uword.act)
			ACT_LOAD: begin
				if (start) begin
					n_q        <= RW'(board_size);
					bad_q      <= (board_size == 5'd0) || (32'(board_size) > Limit);
					col_q      <= '0;
					col_used_q <= '0;
					dn_used_q  <= '0;
					up_used_q  <= '0;
				end
			end
			ACT_INC_COL: col_q <= col_q + RW'(1);
			ACT_PLACE: begin
				col_used_q[col_idx] <= 1'b1;
				dn_used_q[dn_idx]   <= 1'b1;
				up_used_q[up_idx]   <= 1'b1;
				stack_q[row_idx]    <= 4'(col_q);
				col_q               <= '0;
			end
			ACT_POP: col_q <= RW'(stack_q[prev_idx]);
			ACT_UNPLACE: begin
				col_used_q[col_idx] <= 1'b0;
				dn_used_q[dn_idx]   <= 1'b0;
				up_used_q[up_idx]   <= 1'b0;
				col_q               <= col_q + RW'(1);
			end
			ACT_EMIT: begin
				queen_column_q <= stack_q[row_idx];
				is_last_q      <= !flags.not_last;
				impossible_q   <= 1'b0;
			end
			ACT_EMIT_IMP: begin
				queen_column_q <= 4'd0;
				is_last_q      <= 1'b1;
				impossible_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	assign valid        = valid_q;
	assign queen_column = queen_column_q;
	assign is_last      = is_last_q;
	assign impossible   = impossible_q;

endmodule

/* design/n_queens_first_solution.sv */
// ----------------------------------------------------------------------------
// n_queens_first_solution
// Depth-first N-queens search returning the lexicographically first placement,
// one beat per row, run by a microcoded sequencer over a small datapath.
// ----------------------------------------------------------------------------
// Channel   Signals                                  Handshake
// command   start, board_size                        taken when start && !busy
// result    valid, queen_column, is_last, impossible one-cycle strobe, no stall
//
// One control word executes per cycle: a rejected column runs the column
// test, free and next-column steps, a placement column test, free, place
// and row test steps, a backtrack the column test, back, pop and unplace
// steps; a size of zero or above the limit goes to the impossible beat.
// Result beats follow on consecutive cycles, the last marked by is_last.
// Reset clears the step counter and the result strobe; no clearing pass.
// The receiver cannot stall the result beats.
// ----------------------------------------------------------------------------
module n_queens_first_solution #(
	parameter int MAX_BOARD = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] board_size,
	output logic       valid,
	output logic [3:0] queen_column,
	output logic       is_last,
	output logic       impossible
);
	import nqfs_pkg::*;

	uword_t uword;
	flags_t flags;

	nqfs_useq u_useq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.uword (uword),
		.busy  (busy)
	);

	nqfs_dpath #(
		.MAX_BOARD(MAX_BOARD)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.board_size  (board_size),
		.uword       (uword),
		.flags       (flags),
		.valid       (valid),
		.queen_column(queen_column),
		.is_last     (is_last),
		.impossible  (impossible)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_imp_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && impossible |-> is_last)
		else $error("impossible beat not marked last");

	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result beat without a running search");

	a_beat_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_last |=> valid && !impossible)
		else $error("result beats not contiguous");

endmodule

/* sim/tb_n_queens_first_solution.sv */
// ----------------------------------------------------------------------------
// tb_n_queens_first_solution
// Self-checking bench for the N-queens first-solution search. A queue of board
// sizes feeds a clocked command driver. Each accepted command is solved by a
// behavioral backtracking search into a queue of expected row beats. A clocked
// monitor compares every result beat against that queue, field by field.
// ----------------------------------------------------------------------------
module tb_n_queens_first_solution;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxBoard  = 16;
	localparam int DrainAt   = 55;
	localparam int CycleCap  = 20000000;
	localparam int TailWait  = 50;

	typedef struct packed {
		logic [3:0] col;
		logic       last;
		logic       imp;
	} row_beat_t;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [4:0] board_size = '0;
	logic       busy;
	logic       valid;
	logic [3:0] queen_column;
	logic       is_last;
	logic       impossible;

	logic [4:0] board_q[$];
	row_beat_t  placement_q[$];
	int         accepted = 0;
	int         errors   = 0;
	int         cycles   = 0;
	int         idle_pct;
	logic       offer;
	logic       hold;
	row_beat_t  want;
	row_beat_t  got;

	n_queens_first_solution #(.MAX_BOARD(MaxBoard)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.board_size   (board_size),
		.valid        (valid),
		.queen_column (queen_column),
		.is_last      (is_last),
		.impossible   (impossible)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic solve_board(input logic [4:0] size);
		int         n;
		int         row;
		int         c;
		int         from;
		bit         found;
		bit         done;
		bit         placed;
		logic [15:0] col_used;
		logic [30:0] down_used;
		logic [30:0] up_used;
		logic [3:0]  pick[MaxBoard];
		row_beat_t   b;

		n         = size;
		col_used  = '0;
		down_used = '0;
		up_used   = '0;
		found     = 1'b0;
		if (n >= 1 && n <= MaxBoard) begin
			row  = 0;
			from = 0;
			done = 1'b0;
			while (!done) begin
				if (row == n) begin
					found = 1'b1;
					done  = 1'b1;
				end else begin
					placed = 1'b0;
					for (c = from; c < n && !placed; c++) begin
						if (!col_used[c] && !down_used[row + n - 1 - c] && !up_used[row + c]) begin
							col_used[c]              = 1'b1;
							down_used[row + n - 1 - c] = 1'b1;
							up_used[row + c]         = 1'b1;
							pick[row]                = c[3:0];
							placed                   = 1'b1;
						end
					end
					if (placed) begin
						row++;
						from = 0;
					end else if (row == 0) begin
						done = 1'b1;
					end else begin
						row--;
						c                          = pick[row];
						col_used[c]                = 1'b0;
						down_used[row + n - 1 - c] = 1'b0;
						up_used[row + c]           = 1'b0;
						from                       = c + 1;
					end
				end
			end
		end
		if (!found) begin
			b = '{col: 4'd0, last: 1'b1, imp: 1'b1};
			placement_q.push_back(b);
		end else begin
			for (int k = 0; k < n; k++) begin
				b = '{col: pick[k], last: (k == n - 1), imp: 1'b0};
				placement_q.push_back(b);
			end
		end
	endtask

	// Command driver: one beat per start && !busy edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			board_size <= '0;
		end else begin
			offer = start;
			if (start && !busy) begin
				solve_board(board_size);
				void'(board_q.pop_front());
				accepted++;
				offer = 1'b0;
			end
			if (accepted < 40)      idle_pct = 0;
			else if (accepted < 70) idle_pct = 85;
			else if (accepted < 95) idle_pct = 6;
			else                    idle_pct = 0;
			hold = (accepted == DrainAt) && (placement_q.size() != 0);
			if (!offer && board_q.size() != 0 && !hold)
				offer = ($urandom_range(99) >= idle_pct);
			start <= offer;
			if (offer)
				board_size <= board_q[0];
			else if (!start || (start && !busy))
				board_size <= 5'($urandom_range(31));
		end
	end

	// Result monitor: the receiver cannot stall, so take every strobed beat.
	always @(posedge clk) begin
		if (arst_n && valid) begin
			got = '{col: queen_column, last: is_last, imp: impossible};
			if (placement_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: col=%0d last=%0b imp=%0b",
						got.col, got.last, got.imp);
			end else begin
				want = placement_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"beat mismatch: exp col=%0d last=%0b imp=%0b, ",
							"got col=%0d last=%0b imp=%0b"},
							want.col, want.last, want.imp, got.col, got.last, got.imp);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleCap) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int pick;

		board_q = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd0, 5'd31,
			5'd17, 5'd16, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd1, 5'd4};
		for (int i = 0; i < 80; i++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				board_q.push_back(5'($urandom_range(10, 1)));
			else if (pick < 62)
				board_q.push_back(5'd0);
			else if (pick < 85)
				board_q.push_back(5'($urandom_range(31, 17)));
			else if (pick < 97)
				board_q.push_back(5'($urandom_range(12, 11)));
			else
				board_q.push_back(5'd13);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (board_q.size() != 0)
			@(posedge clk);
		while (placement_q.size() != 0)
			@(posedge clk);
		repeat (TailWait) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
